@@ hdl/pcm_mix_pkg.sv @@
// Shared types and constants of the multichannel PCM mixer.
// Depends on nothing; imported by every module of the block.
package pcm_mix_pkg;

  localparam int unsigned CHANNELS_DEF  = 8;
  localparam int unsigned ADDR_BITS_DEF = 16;
  localparam int unsigned VOLUME_MAX    = 64;
  localparam int unsigned ACTION_W      = 3;
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam logic [15:0] STEP_RESET    = 16'd4000;

  typedef enum logic [2:0] {
    ACT_WRITE = 3'd0,
    ACT_START = 3'd1,
    ACT_VOL   = 3'd2,
    ACT_PAN   = 3'd3,
    ACT_TICK  = 3'd4
  } action_e;

  // Register indexes of the APB port
  localparam logic REG_STEP   = 1'b0;
  localparam logic REG_STEREO = 1'b1;

  // Decoded command from front to back
  typedef struct packed {
    logic        is_write;
    logic        is_start;
    logic        is_vol;
    logic        is_pan;
    logic        is_tick;
    logic [2:0]  chan;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [16:0] len;
    logic [6:0]  vol;
    logic [7:0]  pan;
  } cmd_t;

endpackage

@@ hdl/pcm_mix_front.sv @@
// Front end: accepts input beats, classifies and clamps them, and queues
// decoded commands. Depends on pcm_mix_pkg.
module pcm_mix_front import pcm_mix_pkg::*; #(
  parameter int unsigned Channels = CHANNELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [2:0]  channel_index_i,
  input  logic [15:0] mem_address_i,
  input  logic signed [7:0] sample_byte_i,
  input  logic [16:0] play_length_i,
  input  logic [7:0]  level_i,
  input  logic signed [7:0] pan_i,
  output logic        cmd_valid_o,
  output cmd_t        cmd_o,
  input  logic        cmd_pop_i
);

  localparam int unsigned QW = $clog2(QUEUE_DEPTH);

  cmd_t            mem_q [QUEUE_DEPTH];
  logic [QW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QW:0]     cnt_q, cnt_d;
  cmd_t            dec;
  logic            push, pop, chan_ok;

  // Classify and clamp
  always_comb begin
    chan_ok      = ({29'd0, channel_index_i} < 32'(Channels));
    dec          = '0;
    dec.is_write = (action_i == ACT_WRITE);
    dec.is_start = (action_i == ACT_START) && chan_ok;
    dec.is_vol   = (action_i == ACT_VOL) && chan_ok;
    dec.is_pan   = (action_i == ACT_PAN) && chan_ok;
    dec.is_tick  = (action_i == ACT_TICK);
    dec.chan     = channel_index_i;
    dec.addr     = mem_address_i;
    dec.data     = sample_byte_i;
    dec.len      = play_length_i;
    dec.vol      = (level_i > 8'(VOLUME_MAX)) ? 7'(VOLUME_MAX) : level_i[6:0];
    if (pan_i > 8'sd64)       dec.pan = 8'd64;
    else if (pan_i < -8'sd64) dec.pan = 8'hC0;
    else                      dec.pan = pan_i;
  end

  assign in_stall_o  = (cnt_q == (QW+1)'(QUEUE_DEPTH));
  assign push        = in_valid_i && !in_stall_o &&
                       (dec.is_write || dec.is_start || dec.is_vol ||
                        dec.is_pan || dec.is_tick);
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (QW+1)'(push) - (QW+1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      wr_q <= wr_d; rd_q <= rd_d; cnt_q <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QW+1)'(QUEUE_DEPTH)) else $error("queue overfill");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> !pop) else $error("pop of empty queue");
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == (QW+1)'(QUEUE_DEPTH)) |-> in_stall_o) else $error("full not stalled");

endmodule

@@ hdl/pcm_mix_back.sv @@
// Back end: sample memory, channel state and a sequencer that visits each
// channel in turn on a tick, a read and a multiply-accumulate step per channel. Depends on pcm_mix_pkg.
module pcm_mix_back import pcm_mix_pkg::*; #(
  parameter int unsigned Channels = CHANNELS_DEF,
  parameter int unsigned AddrBits = ADDR_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        cmd_pop_o,
  input  logic [15:0] step_i,
  input  logic        stereo_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [7:0] out_primary_o,
  output logic signed [7:0] out_secondary_o,
  output logic [7:0]  out_active_mask_o
);

  localparam int unsigned CW = (Channels > 1) ? $clog2(Channels) : 1;
  localparam int unsigned PW = AddrBits + 1;
  localparam logic [PW-1:0] PTR_MAX = '1;

  typedef enum logic [2:0] {ST_IDLE, ST_GAIN, ST_READ, ST_MAC, ST_DONE} state_e;

  logic signed [7:0] smem [2**AddrBits];
  logic [PW-1:0] rp_q [Channels];
  logic [PW-1:0] ep_q [Channels];
  logic [11:0]   ph_q [Channels];
  logic [Channels-1:0] act_q;
  logic [6:0]    vol_q [Channels];
  logic signed [7:0] pan_q [Channels];
  logic [6:0]    gp_q [Channels];
  logic [6:0]    gs_q [Channels];

  state_e        state_q;
  logic [CW-1:0] ch_q;
  logic [CW-1:0] gch_q;
  logic signed [7:0]  rd_q;
  logic          use_q;
  logic signed [11:0] sp_q, ss_q;
  logic signed [7:0]  op_q, os_q;
  logic [7:0]    mask_q;
  logic          ov_q;

  // Channel and address of the command at the queue head
  logic [CW-1:0]       cch;
  logic [AddrBits-1:0] caddr;

  // Gain computation for one channel
  logic signed [8:0] wp, ws;
  logic [13:0] gpp, gsp;
  // Tick arithmetic for the current channel
  logic [16:0] sum_ph;
  logic [PW:0] np;
  logic signed [14:0] prp, prs;
  logic signed [7:0]  tp, ts;
  logic [PW:0] ep_sum;

  assign cch   = CW'(cmd_i.chan);
  assign caddr = AddrBits'(cmd_i.addr);

  always_comb begin
    wp  = 9'sd64 - 9'(pan_q[gch_q]);
    ws  = 9'sd64 + 9'(pan_q[gch_q]);
    if (wp > 9'sd64) wp = 9'sd64;
    if (ws > 9'sd64) ws = 9'sd64;
    gpp = 14'(wp[6:0]) * 14'(vol_q[gch_q]);
    gsp = 14'(ws[6:0]) * 14'(vol_q[gch_q]);
    sum_ph = {5'd0, ph_q[ch_q]} + {1'b0, step_i};
    np     = {1'b0, rp_q[ch_q]} + (PW+1)'(sum_ph[16:12]);
    prp    = rd_q * $signed({1'b0, gp_q[ch_q]});
    prs    = rd_q * $signed({1'b0, gs_q[ch_q]});
    // truncate toward zero
    tp     = 8'((prp + ((prp < 0) ? 15'sd63 : 15'sd0)) >>> 6);
    ts     = 8'((prs + ((prs < 0) ? 15'sd63 : 15'sd0)) >>> 6);
    ep_sum = (PW+1)'(caddr) + (PW+1)'(cmd_i.len);
  end

  // a tick is held in the queue while a stalled result is pending
  assign cmd_pop_o = cmd_valid_i && (state_q == ST_IDLE) &&
                     !(cmd_i.is_tick && ov_q && out_stall_i);

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && cmd_i.is_write) begin
      smem[caddr] <= cmd_i.data;
    end
    rd_q <= smem[rp_q[ch_q][AddrBits-1:0]];
  end

  // Sequencer and channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; ch_q <= '0; gch_q <= '0; act_q <= '0;
      use_q <= 1'b0; sp_q <= '0; ss_q <= '0; ov_q <= 1'b0;
      op_q <= '0; os_q <= '0; mask_q <= '0;
      for (int i = 0; i < Channels; i++) begin
        rp_q[i] <= '0; ep_q[i] <= '0; ph_q[i] <= '0;
        vol_q[i] <= 7'(VOLUME_MAX); pan_q[i] <= '0;
        gp_q[i] <= 7'(VOLUME_MAX); gs_q[i] <= 7'(VOLUME_MAX);
      end
    end else begin
      if (ov_q && !out_stall_i && (state_q != ST_DONE)) ov_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (cmd_pop_o) begin
            if (cmd_i.is_start) begin
              rp_q[cch] <= PW'(caddr);
              ep_q[cch] <= ep_sum[PW] ? PTR_MAX : ep_sum[PW-1:0];
              act_q[cch] <= 1'b1;
            end else if (cmd_i.is_vol || cmd_i.is_pan) begin
              if (cmd_i.is_vol) vol_q[cch] <= cmd_i.vol;
              else pan_q[cch] <= cmd_i.pan;
              gch_q <= cch;
              state_q <= ST_GAIN;
            end else if (cmd_i.is_tick) begin
              ch_q <= '0; sp_q <= '0; ss_q <= '0;
              state_q <= ST_READ;
            end
          end
        end
        ST_GAIN: begin
          gp_q[gch_q] <= gpp[12:6];
          gs_q[gch_q] <= gsp[12:6];
          state_q <= ST_IDLE;
        end
        ST_READ: begin
          // memory read issued for ch_q; decide channel fate
          use_q <= act_q[ch_q] && (rp_q[ch_q] < ep_q[ch_q]);
          if (act_q[ch_q] && !(rp_q[ch_q] < ep_q[ch_q])) act_q[ch_q] <= 1'b0;
          state_q <= ST_MAC;
        end
        ST_MAC: begin
          if (use_q) begin
            rp_q[ch_q] <= np[PW] ? PTR_MAX : np[PW-1:0];
            ph_q[ch_q] <= sum_ph[11:0];
            sp_q <= sp_q + 12'(tp);
            ss_q <= ss_q + 12'(ts);
          end
          if (32'(ch_q) == Channels - 1) state_q <= ST_DONE;
          else begin
            ch_q <= ch_q + 1'b1;
            state_q <= ST_READ;
          end
        end
        ST_DONE: begin
          if (!ov_q || !out_stall_i) begin
            op_q <= (sp_q > 12'sd127) ? 8'sd127 :
                    (sp_q < -12'sd128) ? -8'sd128 : 8'(sp_q);
            os_q <= !stereo_i ? 8'sd0 : (ss_q > 12'sd127) ? 8'sd127 :
                    (ss_q < -12'sd128) ? -8'sd128 : 8'(ss_q);
            mask_q <= 8'(act_q);
            ov_q <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o       = ov_q;
  assign out_primary_o     = op_q;
  assign out_secondary_o   = os_q;
  assign out_active_mask_o = mask_q;

  a_gain_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(state_q == ST_GAIN) |-> gp_q[$past(gch_q)] <= 7'd64)
    else $error("gain above cap");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> state_q == ST_IDLE) else $error("pop outside idle");
  a_done_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !(ov_q && out_stall_i)) |=> ov_q)
    else $error("tick result lost");

endmodule

@@ hdl/multichannel_pcm_mixer.sv @@
// Multichannel PCM mixer: eight-channel signed 8-bit sample mixer.
// Input channel: action plus fields, valid/stall handshake; one beat per item.
// Output channel: one beat per tick item (primary, secondary, active mask).
// Configuration: APB port, register 0 step increment (0x0), 1 stereo (0x4).
// Sequencing: a tick, after it leaves the queue, takes one memory read and one
// multiply-accumulate per channel, then a done state; volume and panning
// writes pass through a gain recompute state, other items do not.
// A four-entry command queue decouples input from the channel sequencer, so
// input beats are taken while a tick is mixed, until the queue is full.
// The result sits in an output register; while the receiver stalls it holds
// and the next tick waits in the queue or in the sequencer, the queue still
// filling.
// Reset: all channels inactive, volume 64, pan 0, step 4000, mono.
// Sample memory has no reset; it must be written before it is played.
// Depends on pcm_mix_pkg, pcm_mix_front, pcm_mix_back.
module multichannel_pcm_mixer import pcm_mix_pkg::*; #(
  parameter int unsigned Channels = CHANNELS_DEF,
  parameter int unsigned AddrBits = ADDR_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [2:0]  channel_index_i,
  input  logic [15:0] mem_address_i,
  input  logic signed [7:0] sample_byte_i,
  input  logic [16:0] play_length_i,
  input  logic [7:0]  level_i,
  input  logic signed [7:0] pan_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [7:0] out_primary_o,
  output logic signed [7:0] out_secondary_o,
  output logic [7:0]  active_mask_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cmd_t        cmd;
  logic        cmd_valid, cmd_pop;
  logic [15:0] step_q;
  logic        stereo_q;
  logic        wr_en;

  // Configuration registers
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_RESET; stereo_q <= 1'b0;
    end else if (wr_en && paddr[1:0] == 2'b00) begin
      if (paddr[2] == REG_STEP) step_q <= pwdata[15:0];
      else stereo_q <= pwdata[0];
    end
  end
  assign prdata = (paddr[1:0] != 2'b00) ? 32'd0 :
                  (paddr[2] == REG_STEP) ? {16'd0, step_q} : {31'd0, stereo_q};

  pcm_mix_front #(.Channels(Channels)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .action_i, .channel_index_i,
    .mem_address_i, .sample_byte_i, .play_length_i, .level_i, .pan_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  pcm_mix_back #(.Channels(Channels), .AddrBits(AddrBits)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_pop_o(cmd_pop),
    .step_i(step_q), .stereo_i(stereo_q), .out_valid_o, .out_stall_i,
    .out_primary_o, .out_secondary_o, .out_active_mask_o(active_mask_o)
  );

endmodule
